@@ rtl/shqe_pkg.sv @@
// Shared widths, limits and function codes of the substring hash query engine.
package shqe_pkg;

  localparam int MAX_LEN = 4096;
  localparam int IDX_W   = 13;
  localparam int DATA_W  = 64;
  localparam int HALF_W  = DATA_W / 2;
  localparam int FUNC_W  = 2;
  localparam int BYTE_W  = 8;

  localparam logic [IDX_W-1:0]  LEN_MAX    = IDX_W'(MAX_LEN);
  localparam logic [DATA_W-1:0] BASE_RESET = 64'd100000007;

  localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_HASH  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_EQUAL = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_LCP   = 2'd3;

endpackage

@@ rtl/shqe_cfg_if.sv @@
// Configuration write channel carrying the hash base.
interface shqe_cfg_if import shqe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] hash_base;

  modport source (output valid, output hash_base, input ready);
  modport sink   (input valid, input hash_base, output ready);
endinterface

@@ rtl/shqe_in_if.sv @@
// Request channel: load and query transactions.
interface shqe_in_if import shqe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [BYTE_W-1:0] char_byte;
  logic              new_string;
  logic [IDX_W-1:0]  first_start;
  logic [IDX_W-1:0]  first_end;
  logic [IDX_W-1:0]  second_start;
  logic [IDX_W-1:0]  second_end;

  modport source (output valid, output func, output char_byte, output new_string,
                  output first_start, output first_end, output second_start,
                  output second_end, input ready);
  modport sink   (input valid, input func, input char_byte, input new_string,
                  input first_start, input first_end, input second_start,
                  input second_end, output ready);
endinterface

@@ rtl/shqe_out_if.sv @@
// Response channel: query results.
interface shqe_out_if import shqe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] hash_value;
  logic              ranges_equal;
  logic [IDX_W-1:0]  prefix_length;
  logic              range_error;

  modport source (output valid, output hash_value, output ranges_equal,
                  output prefix_length, output range_error, input ready);
  modport sink   (input valid, input hash_value, input ranges_equal,
                  input prefix_length, input range_error, output ready);
endinterface

@@ rtl/substring_hash_query_engine_core.sv @@
// Load: two 64-bit products per transaction (three 32x32 steps each); a load into a full string is dropped.
// Range hash and range equality are paced by the shared 32x32 multiplier
// and the single read port of each hash/power memory (3 reads, 3 multiply steps per hash).
// Suffix common prefix: a binary search hashing two ranges per step, at most 13 steps.
// One transaction at a time; a finished result waits in the output register.
// Synchronous reset empties the string and restores the default base; memories are not cleared.
module substring_hash_query_engine_core import shqe_pkg::*; (
  input logic         clk,
  input logic         rst,
  shqe_cfg_if.sink    cfg,
  shqe_in_if.sink     req,
  shqe_out_if.source  rsp
);

  typedef enum logic [10:0] {
    ST_IDLE      = 11'b000_0000_0001,
    ST_LOAD_POW  = 11'b000_0000_0010,
    ST_LOAD_HASH = 11'b000_0000_0100,
    ST_RD_R      = 11'b000_0000_1000,
    ST_RD_L      = 11'b000_0001_0000,
    ST_RD_WAIT   = 11'b000_0010_0000,
    ST_HASH_MUL  = 11'b000_0100_0000,
    ST_HASH_SUB  = 11'b000_1000_0000,
    ST_LCP_TEST  = 11'b001_0000_0000,
    ST_FINISH    = 11'b010_0000_0000,
    ST_SPARE     = 11'b100_0000_0000
  } state_t;

  localparam logic [1:0] STEP_LAST = 2'd2;

  state_t            state;
  logic [1:0]        step;
  logic [DATA_W-1:0] acc, mul_a, mul_b;
  logic [DATA_W-1:0] base, tail_hash, tail_pow;
  logic [IDX_W-1:0]  len;
  logic [FUNC_W-1:0] q_func;
  logic [IDX_W-1:0]  q_a0, q_a1, q_b0, q_b1;
  logic [BYTE_W-1:0] q_byte;
  logic [IDX_W-1:0]  cur_l, cur_r, lo, hi, mid;
  logic              pass;
  logic [DATA_W-1:0] ph_r, hash_first;
  logic [DATA_W-1:0] res_hash;
  logic              res_eq, res_err;
  logic [IDX_W-1:0]  res_plen;
  logic              out_valid, out_eq, out_err;
  logic [DATA_W-1:0] out_hash;
  logic [IDX_W-1:0]  out_plen;

  // Hash and power memories, entry 0 is implied (0 and 1)
  logic [DATA_W-1:0] ph_mem [0:MAX_LEN];
  logic [DATA_W-1:0] pw_mem [0:MAX_LEN];
  logic [DATA_W-1:0] ph_rd, pw_rd, ph_val, pw_val;
  logic              ph_zero, pw_zero;
  logic [IDX_W-1:0]  ph_raddr, pw_raddr, waddr;
  logic              mem_we;

  // Shared multiplier
  logic [HALF_W-1:0] mul_x, mul_y;
  logic [DATA_W-1:0] prod, addend, acc_next;

  logic              req_fire, a_ok, b_ok, sfx_bad, out_free;
  logic [IDX_W-1:0]  eff_len, far, len_a, len_b;
  logic [IDX_W:0]    mid_sum;
  logic [DATA_W-1:0] hash_res;

  assign req.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;
  assign req_fire  = req.valid && req.ready;

  assign rsp.valid         = out_valid;
  assign rsp.hash_value    = out_hash;
  assign rsp.ranges_equal  = out_eq;
  assign rsp.prefix_length = out_plen;
  assign rsp.range_error   = out_err;
  assign out_free          = !out_valid || rsp.ready;

  always_comb begin
    case (step)
      2'd0: begin
        mul_x = mul_a[HALF_W-1:0];
        mul_y = mul_b[HALF_W-1:0];
      end
      2'd1: begin
        mul_x = mul_a[HALF_W-1:0];
        mul_y = mul_b[DATA_W-1:HALF_W];
      end
      default: begin
        mul_x = mul_a[DATA_W-1:HALF_W];
        mul_y = mul_b[HALF_W-1:0];
      end
    endcase
  end

  assign prod     = {{HALF_W{1'b0}}, mul_x} * {{HALF_W{1'b0}}, mul_y};
  assign addend   = (step == 2'd0) ? prod : {prod[HALF_W-1:0], {HALF_W{1'b0}}};
  assign acc_next = acc + addend;

  assign ph_val   = ph_zero ? '0 : ph_rd;
  assign pw_val   = pw_zero ? DATA_W'(1) : pw_rd;
  assign ph_raddr = (state == ST_RD_R) ? cur_r : cur_l;
  assign pw_raddr = cur_r - cur_l;
  assign waddr    = len + IDX_W'(1);
  assign mem_we   = (state == ST_LOAD_HASH) && (step == STEP_LAST);

  assign eff_len  = req.new_string ? '0 : len;
  assign a_ok     = (req.first_start <= req.first_end) && (req.first_end <= len);
  assign b_ok     = (req.second_start <= req.second_end) && (req.second_end <= len);
  assign sfx_bad  = (req.first_start > len) || (req.second_start > len);
  assign far      = (req.first_start > req.second_start) ? req.first_start
                                                         : req.second_start;
  assign mid_sum  = {1'b0, lo} + {1'b0, hi} + (IDX_W+1)'(1);
  assign hash_res = ph_r - acc;
  assign len_a    = q_a1 - q_a0;
  assign len_b    = q_b1 - q_b0;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ph_mem[waddr] <= acc_next;
      pw_mem[waddr] <= tail_pow;
    end
    ph_rd   <= ph_mem[ph_raddr];
    pw_rd   <= pw_mem[pw_raddr];
    ph_zero <= (ph_raddr == '0);
    pw_zero <= (pw_raddr == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      len       <= '0;
      tail_hash <= '0;
      tail_pow  <= DATA_W'(1);
      base      <= BASE_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        base <= cfg.hash_base;
      end
      // the finish step reloads the output register itself
      if (out_valid && rsp.ready && state != ST_FINISH) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req_fire) begin
            q_func   <= req.func;
            q_byte   <= req.char_byte;
            q_a0     <= req.first_start;
            q_a1     <= req.first_end;
            q_b0     <= req.second_start;
            q_b1     <= req.second_end;
            res_hash <= '0;
            res_eq   <= 1'b0;
            res_plen <= '0;
            pass     <= 1'b0;
            cur_l    <= req.first_start;
            cur_r    <= req.first_end;
            case (req.func)
              FUNC_LOAD: begin
                if (req.new_string) begin
                  len       <= '0;
                  tail_hash <= '0;
                  tail_pow  <= DATA_W'(1);
                end
                mul_a <= req.new_string ? DATA_W'(1) : tail_pow;
                mul_b <= base;
                acc   <= '0;
                step  <= '0;
                // drop the byte when the string is full
                if (eff_len < LEN_MAX) begin
                  state <= ST_LOAD_POW;
                end
              end
              FUNC_HASH: begin
                res_err <= !a_ok;
                state   <= a_ok ? ST_RD_R : ST_FINISH;
              end
              FUNC_EQUAL: begin
                res_err <= !(a_ok && b_ok);
                state   <= (a_ok && b_ok) ? ST_RD_R : ST_FINISH;
              end
              FUNC_LCP: begin
                res_err <= sfx_bad;
                lo      <= '0;
                hi      <= len - far;
                state   <= sfx_bad ? ST_FINISH : ST_LCP_TEST;
              end
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_LOAD_POW: begin
          if (step == STEP_LAST) begin
            tail_pow <= acc_next;
            mul_a    <= tail_hash;
            acc      <= DATA_W'(q_byte) + DATA_W'(1);
            step     <= '0;
            state    <= ST_LOAD_HASH;
          end else begin
            acc  <= acc_next;
            step <= step + 2'd1;
          end
        end
        ST_LOAD_HASH: begin
          if (step == STEP_LAST) begin
            tail_hash <= acc_next;
            len       <= waddr;
            step      <= '0;
            state     <= ST_IDLE;
          end else begin
            acc  <= acc_next;
            step <= step + 2'd1;
          end
        end
        ST_RD_R: begin
          state <= ST_RD_L;
        end
        ST_RD_L: begin
          ph_r  <= ph_val;
          mul_b <= pw_val;
          state <= ST_RD_WAIT;
        end
        ST_RD_WAIT: begin
          mul_a <= ph_val;
          acc   <= '0;
          step  <= '0;
          state <= ST_HASH_MUL;
        end
        ST_HASH_MUL: begin
          acc <= acc_next;
          if (step == STEP_LAST) begin
            step  <= '0;
            state <= ST_HASH_SUB;
          end else begin
            step <= step + 2'd1;
          end
        end
        ST_HASH_SUB: begin
          case (q_func)
            FUNC_HASH: begin
              res_hash <= hash_res;
              state    <= ST_FINISH;
            end
            FUNC_EQUAL: begin
              if (!pass) begin
                hash_first <= hash_res;
                pass       <= 1'b1;
                cur_l      <= q_b0;
                cur_r      <= q_b1;
                state      <= ST_RD_R;
              end else begin
                res_eq <= (len_a == len_b) && (hash_first == hash_res);
                state  <= ST_FINISH;
              end
            end
            default: begin
              if (!pass) begin
                hash_first <= hash_res;
                pass       <= 1'b1;
                cur_l      <= q_b0;
                cur_r      <= q_b0 + mid;
                state      <= ST_RD_R;
              end else begin
                // keep the lower half on a mismatch
                if (hash_first == hash_res) begin
                  lo <= mid;
                end else begin
                  hi <= mid - IDX_W'(1);
                end
                state <= ST_LCP_TEST;
              end
            end
          endcase
        end
        ST_LCP_TEST: begin
          if (lo < hi) begin
            mid   <= mid_sum[IDX_W:1];
            cur_l <= q_a0;
            cur_r <= q_a0 + mid_sum[IDX_W:1];
            pass  <= 1'b0;
            state <= ST_RD_R;
          end else begin
            res_plen <= lo;
            state    <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_hash  <= res_hash;
            out_eq    <= res_eq;
            out_plen  <= res_plen;
            out_err   <= res_err;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= LEN_MAX)
    else $error("string length exceeds its limit");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD_POW || state == ST_LOAD_HASH || state == ST_HASH_MUL)
      |-> step <= STEP_LAST)
    else $error("multiplier step counter out of range");

  a_search_order: assert property (@(posedge clk) disable iff (rst)
    (q_func == FUNC_LCP && state == ST_LCP_TEST) |-> lo <= hi)
    else $error("binary search bounds crossed");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_FINISH))
    else $error("result raised outside the finish step");

  a_load_starts: assert property (@(posedge clk) disable iff (rst)
    (req_fire && req.func == FUNC_LOAD && !req.new_string && len < LEN_MAX)
      |=> state == ST_LOAD_POW && $past(len) == len)
    else $error("accepted load did not start its products");
`endif

endmodule
